[sv/imi_pkg.sv]
package imi_pkg;

	localparam int NUM_CENTROIDS  = 64;
	localparam int NUM_SUBSPACES  = 8;
	localparam int ID_BITS        = 6;
	localparam int SUB_BITS       = 3;
	localparam int COUNT_BITS     = 21;
	localparam int DIST_BITS      = 31;
	localparam int ROW_DIST_BITS  = DIST_BITS + 1;
	localparam int AMOUNT_BITS    = 20;
	localparam int TARGET_BITS    = 20;
	localparam int ACT_BITS       = ID_BITS + 1;
	localparam int CELL_ADDR_BITS = SUB_BITS + 2 * ID_BITS;
	localparam int CELL_DEPTH     = NUM_SUBSPACES * NUM_CENTROIDS * NUM_CENTROIDS;
	localparam int LIST_BITS      = ID_BITS + DIST_BITS;
	localparam int ROW_BITS       = ID_BITS + ROW_DIST_BITS;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_LOAD  = 2'd1,
		OP_START = 2'd2,
		OP_NEXT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_LOAD,
		ST_START_RD,
		ST_START_WR,
		ST_NEXT,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK,
		ST_CELL_RD,
		ST_CELL,
		ST_OPEN,
		ST_CHECK,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t                    operation;
		logic [SUB_BITS-1:0]    subspace;
		logic [ID_BITS-1:0]     cell_first;
		logic [ID_BITS-1:0]     cell_second;
		logic [AMOUNT_BITS-1:0] add_amount;
		logic [ID_BITS-1:0]     list_pos;
		logic [ID_BITS-1:0]     first_id;
		logic [DIST_BITS-1:0]   first_dist;
		logic [ID_BITS-1:0]     second_id;
		logic [DIST_BITS-1:0]   second_dist;
	} in_item_t;

	typedef struct packed {
		logic                  has_cell;
		logic [ID_BITS-1:0]    found_first;
		logic [ID_BITS-1:0]    found_second;
		logic [COUNT_BITS-1:0] cell_count;
		logic [COUNT_BITS-1:0] retrieved_total;
		logic                  finished;
	} out_item_t;

	typedef struct packed {
		logic clr_step;
		logic take;
		logic add_wr;
		logic load_wr;
		logic start_rd;
		logic start_wr;
		logic next_init;
		logic scan_init;
		logic scan_issue;
		logic pick_rd;
		logic cell_rd;
		logic cell_eval;
		logic open_wr;
		logic fin_set;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic run;
		logic scan_last;
		logic found;
		logic reached;
		logic has;
		logic any_live;
		logic out_free;
	} status_t;

endpackage

[sv/imi_cell_dynamic_activation_unit.sv]
// Inverted multi-index cell traversal. A 32768-entry bucket count table covers all eight subspaces;
// after reset the block sweeps it to zero with in_ready low (configuration writes are always
// taken). An add item reads its cell, then writes the saturated sum back; a load writes one
// entry of both lists; a start reads the head of both lists, then opens row zero. For a next item,
// each probe scans the row table through the single read port of the row memory,
// one row a cycle, then reads both centroid lists and the count table in turn. Results wait in
// an output register; a new item is taken once the previous one has finished its work.
module imi_cell_dynamic_activation_unit import imi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [TARGET_BITS-1:0] cfg_data
);

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	imi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_op   (in_data.operation),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	imi_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

[sv/imi_ram.sv]
module imi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/imi_ctrl.sv]
module imi_ctrl import imi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  op_t     in_op,
	output logic    in_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					case (in_op)
						OP_ADD:   state_n = ST_ADD_RD;
						OP_LOAD:  state_n = ST_LOAD;
						OP_START: state_n = ST_START_RD;
						OP_NEXT:  state_n = ST_NEXT;
						default:  state_n = ST_IDLE;
					endcase
				end
			end
			ST_ADD_RD: state_n = ST_ADD_WR;
			ST_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_n = ST_IDLE;
			end
			ST_LOAD: begin
				cmd.load_wr = 1'b1;
				state_n = ST_IDLE;
			end
			ST_START_RD: begin
				cmd.start_rd = 1'b1;
				state_n = ST_START_WR;
			end
			ST_START_WR: begin
				cmd.start_wr = 1'b1;
				state_n = ST_IDLE;
			end
			ST_NEXT: begin
				cmd.next_init = 1'b1;
				cmd.scan_init = 1'b1;
				state_n = sts.run ? ST_SCAN : ST_OUT;
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_n = ST_SCAN_END;
				end
			end
			ST_SCAN_END: state_n = ST_PICK;
			ST_PICK: begin
				if (sts.found) begin
					cmd.pick_rd = 1'b1;
					state_n = ST_CELL_RD;
				end else begin
					cmd.fin_set = 1'b1;
					state_n = ST_OUT;
				end
			end
			ST_CELL_RD: begin
				cmd.cell_rd = 1'b1;
				state_n = ST_CELL;
			end
			ST_CELL: begin
				cmd.cell_eval = 1'b1;
				state_n = sts.reached ? ST_OUT : ST_OPEN;
			end
			ST_OPEN: begin
				cmd.open_wr = 1'b1;
				state_n = ST_CHECK;
			end
			ST_CHECK: begin
				if (!sts.any_live) begin
					cmd.fin_set = 1'b1;
					state_n = ST_OUT;
				end else if (sts.has) begin
					state_n = ST_OUT;
				end else begin
					cmd.scan_init = 1'b1;
					state_n = ST_SCAN;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

[sv/imi_dpath.sv]
module imi_dpath import imi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                sts,
	input  in_item_t               in_data,
	input  logic                   cfg_we,
	input  logic [TARGET_BITS-1:0] cfg_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_data
);

	localparam logic [ID_BITS-1:0] LAST = ID_BITS'(NUM_CENTROIDS - 1);

	in_item_t                    item_q;
	logic [TARGET_BITS-1:0]      target_q;
	logic [CELL_ADDR_BITS-1:0]   clr_addr_q;
	phase_t                      phase_q;
	logic [SUB_BITS-1:0]         run_sub_q;
	logic [COUNT_BITS-1:0]       sum_q;
	logic [ACT_BITS-1:0]         active_q;
	logic [NUM_CENTROIDS-1:0]    spent_q;
	logic [DIST_BITS-1:0]        sd0_q;
	logic [ID_BITS-1:0]          scan_idx_q;
	logic                        scan_v_s1;
	logic [ID_BITS-1:0]          scan_idx_s1;
	logic                        found_q;
	logic [ID_BITS-1:0]          best_pos_q;
	logic [ID_BITS-1:0]          best_ptr_q;
	logic [ROW_DIST_BITS-1:0]    best_dist_q;
	logic [ID_BITS-1:0]          id1_q;
	logic [ID_BITS-1:0]          id2_q;
	logic [DIST_BITS-1:0]        fd_pos_q;
	logic [DIST_BITS-1:0]        fd_next_q;
	logic                        has_q;
	logic [ID_BITS-1:0]          fa_q;
	logic [ID_BITS-1:0]          fb_q;
	logic [COUNT_BITS-1:0]       cnt_q;
	logic                        out_valid_q;
	out_item_t                   out_q;

	logic                        cell_we;
	logic [CELL_ADDR_BITS-1:0]   cell_waddr, cell_raddr, item_addr;
	logic [COUNT_BITS-1:0]       cell_wdata, cell_rdata;
	logic [COUNT_BITS:0]         add_sum, run_sum;
	logic [COUNT_BITS-1:0]       add_sat, run_sat;
	logic [ID_BITS-1:0]          f_raddr, s_raddr;
	logic [LIST_BITS-1:0]        f_rdata, s_rdata;
	logic [ID_BITS-1:0]          f_id, s_id;
	logic [DIST_BITS-1:0]        f_dist, s_dist;
	logic                        row_we;
	logic [ID_BITS-1:0]          row_waddr;
	logic [ROW_BITS-1:0]         row_wdata, row_rdata;
	logic [ID_BITS-1:0]          row_ptr;
	logic [ROW_DIST_BITS-1:0]    row_dist;
	logic                        cnt_nz, reached, advance, open_need, live;
	logic [ID_BITS-1:0]          pos_inc, ptr_inc;

	assign item_addr = {item_q.subspace, item_q.cell_first, item_q.cell_second};
	assign {f_id, f_dist} = f_rdata;
	assign {s_id, s_dist} = s_rdata;
	assign {row_ptr, row_dist} = row_rdata;
	assign pos_inc = best_pos_q + ID_BITS'(1);
	assign ptr_inc = best_ptr_q + ID_BITS'(1);

	// cell counts
	assign add_sum    = {1'b0, cell_rdata} + (COUNT_BITS+1)'(item_q.add_amount);
	assign add_sat    = add_sum[COUNT_BITS] ? '1 : add_sum[COUNT_BITS-1:0];
	assign cell_we    = cmd.clr_step | cmd.add_wr;
	assign cell_waddr = cmd.clr_step ? clr_addr_q : item_addr;
	assign cell_wdata = cmd.clr_step ? '0 : add_sat;
	assign cell_raddr = cmd.cell_rd ? {run_sub_q, f_id, s_id} : item_addr;

	imi_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELL_DEPTH)) u_cells (
		.clk  (clk),
		.we   (cell_we),
		.waddr(cell_waddr),
		.wdata(cell_wdata),
		.raddr(cell_raddr),
		.rdata(cell_rdata)
	);

	// sorted lists
	always_comb begin
		if (cmd.start_rd) begin
			f_raddr = '0;
			s_raddr = '0;
		end else if (cmd.pick_rd) begin
			f_raddr = best_pos_q;
			s_raddr = best_ptr_q;
		end else begin
			f_raddr = pos_inc;
			s_raddr = ptr_inc;
		end
	end

	imi_ram #(.WIDTH(LIST_BITS), .DEPTH(NUM_CENTROIDS)) u_first (
		.clk  (clk),
		.we   (cmd.load_wr),
		.waddr(item_q.list_pos),
		.wdata({item_q.first_id, item_q.first_dist}),
		.raddr(f_raddr),
		.rdata(f_rdata)
	);

	imi_ram #(.WIDTH(LIST_BITS), .DEPTH(NUM_CENTROIDS)) u_second (
		.clk  (clk),
		.we   (cmd.load_wr),
		.waddr(item_q.list_pos),
		.wdata({item_q.second_id, item_q.second_dist}),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	// traversal step evaluation
	assign cnt_nz  = cell_rdata != '0;
	assign run_sum = {1'b0, sum_q} + {1'b0, cell_rdata};
	assign run_sat = run_sum[COUNT_BITS] ? '1 : run_sum[COUNT_BITS-1:0];
	assign reached = cnt_nz && (run_sat >= COUNT_BITS'(target_q));
	assign advance = cmd.cell_eval && !reached && (best_ptr_q != LAST);
	assign open_need = (best_ptr_q == '0) && (best_pos_q != LAST) &&
		(active_q <= ACT_BITS'(best_pos_q) + ACT_BITS'(1));

	// row table
	always_comb begin
		row_we    = 1'b0;
		row_waddr = best_pos_q;
		row_wdata = {ptr_inc, ROW_DIST_BITS'(fd_pos_q) + ROW_DIST_BITS'(s_dist)};
		if (cmd.start_wr) begin
			row_we    = 1'b1;
			row_waddr = '0;
			row_wdata = {ID_BITS'(0), ROW_DIST_BITS'(f_dist) + ROW_DIST_BITS'(s_dist)};
		end else if (advance) begin
			row_we = 1'b1;
		end else if (cmd.open_wr && open_need) begin
			row_we    = 1'b1;
			row_waddr = pos_inc;
			row_wdata = {ID_BITS'(0), ROW_DIST_BITS'(fd_next_q) + ROW_DIST_BITS'(sd0_q)};
		end
	end

	imi_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_CENTROIDS)) u_rows (
		.clk  (clk),
		.we   (row_we),
		.waddr(row_waddr),
		.wdata(row_wdata),
		.raddr(scan_idx_q),
		.rdata(row_rdata)
	);

	// any unexhausted row among the active ones
	always_comb begin
		live = 1'b0;
		for (int r = 0; r < NUM_CENTROIDS; r++) begin
			live = live | (!spent_q[r] && (ACT_BITS'(r) < active_q));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= in_data;
		end
		if (cmd.load_wr && item_q.list_pos == '0) begin
			sd0_q <= item_q.second_dist;
		end
		scan_idx_s1 <= scan_idx_q;
		if (scan_v_s1 && !spent_q[scan_idx_s1] && (!found_q || row_dist < best_dist_q)) begin
			best_pos_q  <= scan_idx_s1;
			best_ptr_q  <= row_ptr;
			best_dist_q <= row_dist;
		end
		if (cmd.cell_rd) begin
			id1_q    <= f_id;
			id2_q    <= s_id;
			fd_pos_q <= f_dist;
		end
		if (cmd.cell_eval) begin
			fd_next_q <= f_dist;
		end
		if (cmd.out_load) begin
			out_q.has_cell        <= has_q;
			out_q.found_first     <= fa_q;
			out_q.found_second    <= fb_q;
			out_q.cell_count      <= cnt_q;
			out_q.retrieved_total <= sum_q;
			out_q.finished        <= phase_q != PH_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= TARGET_BITS'(1);
			clr_addr_q  <= '0;
			phase_q     <= PH_IDLE;
			run_sub_q   <= '0;
			sum_q       <= '0;
			active_q    <= '0;
			spent_q     <= '0;
			scan_idx_q  <= '0;
			scan_v_s1   <= 1'b0;
			found_q     <= 1'b0;
			has_q       <= 1'b0;
			fa_q        <= '0;
			fb_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				target_q <= cfg_data;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + CELL_ADDR_BITS'(1);
			end
			if (cmd.start_wr) begin
				run_sub_q  <= item_q.subspace;
				sum_q      <= '0;
				active_q   <= ACT_BITS'(1);
				spent_q[0] <= 1'b0;
				phase_q    <= PH_RUN;
			end
			if (cmd.fin_set) begin
				phase_q <= PH_DONE;
			end
			if (cmd.next_init) begin
				has_q <= 1'b0;
				fa_q  <= '0;
				fb_q  <= '0;
				cnt_q <= '0;
			end
			scan_v_s1 <= cmd.scan_issue;
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else if (cmd.scan_issue) begin
				scan_idx_q <= scan_idx_q + ID_BITS'(1);
			end
			if (scan_v_s1 && !spent_q[scan_idx_s1]) begin
				found_q <= 1'b1;
			end
			if (cmd.cell_eval) begin
				if (cnt_nz) begin
					has_q <= 1'b1;
					fa_q  <= id1_q;
					fb_q  <= id2_q;
					cnt_q <= cell_rdata;
					sum_q <= run_sat;
				end
				if (reached) begin
					phase_q <= PH_DONE;
				end else if (best_ptr_q == LAST) begin
					spent_q[best_pos_q] <= 1'b1;
				end
			end
			if (cmd.open_wr && open_need) begin
				spent_q[pos_inc] <= 1'b0;
				active_q         <= ACT_BITS'(best_pos_q) + ACT_BITS'(2);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_done  = &clr_addr_q;
	assign sts.run       = phase_q == PH_RUN;
	assign sts.scan_last = scan_idx_q == ID_BITS'(active_q - ACT_BITS'(1));
	assign sts.found     = found_q;
	assign sts.reached   = reached;
	assign sts.has       = has_q;
	assign sts.any_live  = live;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[dv/tb_imi_cell_dynamic_activation_unit.sv]
`timescale 1ns / 1ps

module tb_imi_cell_dynamic_activation_unit;
	import imi_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	in_item_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_item_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [TARGET_BITS-1:0] cfg_data;

	imi_cell_dynamic_activation_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// predicted block state
	bit   [COUNT_BITS-1:0]    bucket [CELL_DEPTH];
	logic [ID_BITS-1:0]       rank_first_id [NUM_CENTROIDS];
	logic [DIST_BITS-1:0]     rank_first_dist [NUM_CENTROIDS];
	logic [ID_BITS-1:0]       rank_second_id [NUM_CENTROIDS];
	logic [DIST_BITS-1:0]     rank_second_dist [NUM_CENTROIDS];
	logic [ROW_DIST_BITS-1:0] row_sum [NUM_CENTROIDS];
	int                       row_ptr [NUM_CENTROIDS];
	bit                       row_done [NUM_CENTROIDS];
	int                       open_rows = 0;
	logic [COUNT_BITS-1:0]    total_seen = '0;
	logic [SUB_BITS-1:0]      walk_sub = '0;
	phase_t                   walk_phase = PH_IDLE;
	logic [TARGET_BITS-1:0]   stop_target = TARGET_BITS'(1);

	in_item_t  pending_items [$];
	out_item_t cells_due [$];
	bit        failed = 0;
	bit        calm = 0;
	int        results_seen = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("imi_cell_dynamic_activation_unit: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function void open_row(int r);
		row_ptr[r] = 0;
		row_done[r] = 0;
		row_sum[r] = {1'b0, rank_first_dist[r]} + {1'b0, rank_second_dist[0]};
	endfunction

	// walk rows in order of summed distance until a nonempty cell or the end
	function out_item_t walk_next();
		out_item_t res;
		bit found;
		bit any;
		int pos;
		int ptr;
		logic [ID_BITS-1:0] c1;
		logic [ID_BITS-1:0] c2;
		logic [COUNT_BITS-1:0] cnt;
		logic [COUNT_BITS:0] t;
		res = '0;
		found = 0;
		while (walk_phase == PH_RUN && !found) begin
			any = 0;
			pos = 0;
			for (int r = 0; r < open_rows; r++)
				if (!row_done[r] && (!any || row_sum[r] < row_sum[pos])) begin
					pos = r;
					any = 1;
				end
			if (!any) begin
				walk_phase = PH_DONE;
				break;
			end
			ptr = row_ptr[pos];
			c1 = rank_first_id[pos];
			c2 = rank_second_id[ptr];
			cnt = bucket[{walk_sub, c1, c2}];
			if (cnt != 0) begin
				found = 1;
				res.found_first = c1;
				res.found_second = c2;
				res.cell_count = cnt;
				t = {1'b0, total_seen} + {1'b0, cnt};
				total_seen = (t > COUNT_SAT) ? COUNT_SAT : t[COUNT_BITS-1:0];
				if (total_seen >= stop_target) begin
					walk_phase = PH_DONE;
					break;
				end
			end
			if (ptr == 0 && pos + 1 < NUM_CENTROIDS && open_rows <= pos + 1) begin
				open_row(pos + 1);
				open_rows = pos + 2;
			end
			if (ptr + 1 < NUM_CENTROIDS) begin
				row_ptr[pos] = ptr + 1;
				row_sum[pos] = {1'b0, rank_first_dist[pos]} + {1'b0, rank_second_dist[ptr + 1]};
			end else begin
				row_done[pos] = 1;
			end
			any = 0;
			for (int r = 0; r < open_rows; r++)
				if (!row_done[r])
					any = 1;
			if (!any)
				walk_phase = PH_DONE;
		end
		res.has_cell = found;
		res.retrieved_total = total_seen;
		res.finished = (walk_phase != PH_RUN);
		return res;
	endfunction

	function void apply_item(in_item_t it);
		logic [COUNT_BITS:0] v;
		logic [CELL_ADDR_BITS-1:0] idx;
		case (it.operation)
			OP_ADD: begin
				idx = {it.subspace, it.cell_first, it.cell_second};
				v = {1'b0, bucket[idx]} + (COUNT_BITS+1)'(it.add_amount);
				bucket[idx] = (v > COUNT_SAT) ? COUNT_SAT : v[COUNT_BITS-1:0];
			end
			OP_LOAD: begin
				rank_first_id[it.list_pos] = it.first_id;
				rank_first_dist[it.list_pos] = it.first_dist;
				rank_second_id[it.list_pos] = it.second_id;
				rank_second_dist[it.list_pos] = it.second_dist;
			end
			OP_START: begin
				walk_sub = it.subspace;
				total_seen = '0;
				open_rows = 1;
				open_row(0);
				walk_phase = PH_RUN;
			end
			OP_NEXT: cells_due.insert(cells_due.size(), walk_next());
			default: ;
		endcase
	endfunction

	function void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1;
		end
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && in_ready)
				apply_item(in_data);
			if (in_valid && !in_ready) begin
				// hold the offered item
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 0;
			end else if (pending_items.size() != 0) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1;
				send_gap = calm ? 0 : pick_gap();
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	int stall_left = 0;
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (cells_due.size() == 0) begin
					$error("result with no item pending");
					failed = 1;
				end else begin
					want = cells_due.pop_front();
					check_field("has_cell", want.has_cell, out_data.has_cell);
					check_field("found_first", want.found_first, out_data.found_first);
					check_field("found_second", want.found_second, out_data.found_second);
					check_field("cell_count", want.cell_count, out_data.cell_count);
					check_field("retrieved_total", want.retrieved_total,
						out_data.retrieved_total);
					check_field("finished", want.finished, out_data.finished);
				end
				// long hold lets the block back up into its input
				if (results_seen == 150 || results_seen == 700)
					stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 0;
			end else if (!calm && $urandom_range(0, 99) < 15) begin
				stall_left = pick_gap();
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	function automatic in_item_t noise_item();
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
		return it;
	endfunction

	task automatic add_cell(logic [SUB_BITS-1:0] s, logic [ID_BITS-1:0] a,
			logic [ID_BITS-1:0] b, logic [AMOUNT_BITS-1:0] amt);
		in_item_t it;
		it = noise_item();
		it.operation = OP_ADD;
		it.subspace = s;
		it.cell_first = a;
		it.cell_second = b;
		it.add_amount = amt;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic load_rank(int p, logic [ID_BITS-1:0] fid, logic [DIST_BITS-1:0] fd,
			logic [ID_BITS-1:0] sid, logic [DIST_BITS-1:0] sd);
		in_item_t it;
		it = noise_item();
		it.operation = OP_LOAD;
		it.list_pos = ID_BITS'(p);
		it.first_id = fid;
		it.first_dist = fd;
		it.second_id = sid;
		it.second_dist = sd;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic push_op(op_t op, logic [SUB_BITS-1:0] s);
		in_item_t it;
		it = noise_item();
		it.operation = op;
		it.subspace = s;
		pending_items.insert(pending_items.size(), it);
	endtask

	// mode 0 ascending with ties, 1 unordered, 2 all at the largest distance
	task automatic load_lists(logic [ID_BITS-1:0] b1, logic [ID_BITS-1:0] b2, int mode);
		logic [DIST_BITS-1:0] d1;
		logic [DIST_BITS-1:0] d2;
		d1 = '0;
		d2 = '0;
		for (int p = 0; p < NUM_CENTROIDS; p++) begin
			if (mode == 1) begin
				d1 = DIST_BITS'($urandom);
				d2 = DIST_BITS'($urandom);
			end else if (mode == 2) begin
				d1 = '1;
				d2 = '1;
			end else if (p != 0) begin
				if ($urandom_range(0, 3) != 0)
					d1 = d1 + DIST_BITS'($urandom_range(0, 1 << 24));
				if ($urandom_range(0, 3) != 0)
					d2 = d2 + DIST_BITS'($urandom_range(0, 1 << 24));
			end
			load_rank(p, b1 + ID_BITS'($urandom_range(0, 3)), d1,
				b2 + ID_BITS'($urandom_range(0, 3)), d2);
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || in_valid || cells_due.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_target(logic [TARGET_BITS-1:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk);
		while (!cfg_ready);
		stop_target = v;
		cfg_valid <= 0;
	endtask

	initial begin
		logic [SUB_BITS-1:0] s;
		logic [ID_BITS-1:0] b1;
		logic [ID_BITS-1:0] b2;
		int r;
		in_valid <= 0;
		in_data <= '0;
		cfg_valid <= 0;
		cfg_data <= '0;
		arst_n <= 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed: next with no traversal open
		push_op(OP_NEXT, '0);
		// an empty subspace runs every row to exhaustion, all distances tied
		load_lists(6'h00, 6'h3c, 2);
		push_op(OP_START, SUB_BITS'(7));
		push_op(OP_NEXT, SUB_BITS'(7));
		push_op(OP_NEXT, SUB_BITS'(7));
		// large cell count, just below saturation, with the default target of one
		load_lists(6'h3c, 6'h00, 0);
		wait_idle();
		add_cell('0, rank_first_id[0], rank_second_id[0], '1);
		add_cell('0, rank_first_id[0], rank_second_id[0], '1);
		add_cell('0, 6'h3f, 6'h3f, '0);
		push_op(OP_START, '0);
		push_op(OP_NEXT, '0);
		push_op(OP_NEXT, '0);
		wait_idle();

		for (int k = 0; k < 10; k++) begin
			calm = (k % 4 == 1);
			if (k == 0)
				write_target('1);
			else if (k == 1)
				write_target(TARGET_BITS'(1));
			else if (k % 3 == 0)
				write_target(TARGET_BITS'($urandom_range(1, (1 << TARGET_BITS) - 1)));
			else
				write_target(TARGET_BITS'($urandom_range(1, 200000)));
			s = SUB_BITS'($urandom_range(0, NUM_SUBSPACES - 1));
			b1 = ID_BITS'($urandom);
			b2 = ID_BITS'($urandom);
			load_lists(b1, b2, (k % 5 == 3) ? 1 : (k % 5 == 4) ? 2 : 0);
			for (int a = 0; a < 4; a++)
				for (int b = 0; b < 4; b++)
					add_cell(s, b1 + ID_BITS'(a), b2 + ID_BITS'(b),
						($urandom_range(0, 3) == 0) ? AMOUNT_BITS'($urandom) :
						AMOUNT_BITS'($urandom_range(1, 5000)));
			push_op(OP_START, s);
			for (int n = 0; n < 100; n++) begin
				r = $urandom_range(0, 99);
				if (r < 75)
					push_op(OP_NEXT, SUB_BITS'($urandom));
				else if (r < 85)
					add_cell(s, b1 + ID_BITS'($urandom_range(0, 3)),
						b2 + ID_BITS'($urandom_range(0, 3)), AMOUNT_BITS'($urandom));
				else if (r < 92)
					add_cell(SUB_BITS'($urandom), ID_BITS'($urandom), ID_BITS'($urandom),
						AMOUNT_BITS'($urandom));
				else if (r < 96)
					load_rank($urandom_range(0, NUM_CENTROIDS - 1), ID_BITS'($urandom),
						DIST_BITS'($urandom), ID_BITS'($urandom), DIST_BITS'($urandom));
				else
					push_op(OP_START, s);
			end
			wait_idle();
		end

		if (!failed)
			$display("imi_cell_dynamic_activation_unit: match");
		else
			$display("imi_cell_dynamic_activation_unit: mismatch");
		$finish;
	end

endmodule
